[hw/rtl/rda_pkg.sv]
// rda_pkg: widths, codes and state types for the rotary dial acceleration block
// no dependencies; imported by the interfaces, the top level and the checker

package rda_pkg;

	localparam int TIME_WIDTH  = 32;
	localparam int GUARD_W     = 8;
	localparam int STEP_W      = 30;
	localparam int CNT_W       = 3;
	localparam logic [CNT_W-1:0] COUNT_MAX = 3'd7;
	localparam logic [GUARD_W-1:0] GUARD_RESET = 8'd10;

	// dividend is 2^(4*count), so the quotient needs 4*COUNT_MAX+1 bits
	localparam int QUO_W     = 4 * int'(COUNT_MAX) + 1;
	localparam int DIV_CNT_W = $clog2(QUO_W);

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_CW   = 2'd1,
		DIR_CCW  = 2'd2
	} dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

[hw/rtl/rda_if.sv]
// rda_if: valid/ready channel interfaces for detent beats, step beats and config writes
// depends on rda_pkg for field widths

interface rda_in_if import rda_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  direction;
	logic [TIME_WIDTH-1:0] event_time;

	modport source  (output valid, direction, event_time, input ready);
	modport sink    (input valid, direction, event_time, output ready);
	modport monitor (input valid, ready, direction, event_time);
endinterface

interface rda_out_if import rda_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [STEP_W-1:0] step;

	modport source  (output valid, step, input ready);
	modport sink    (input valid, step, output ready);
	modport monitor (input valid, ready, step);
endinterface

interface rda_cfg_if import rda_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [GUARD_W-1:0] data;

	modport source  (output valid, data, input ready);
	modport sink    (input valid, data, output ready);
	modport monitor (input valid, ready, data);
endinterface

[hw/rtl/rotary_dial_acceleration.sv]
// rotary_dial_acceleration: turns encoder detent beats into signed accelerated steps
// depends on rda_pkg and the channel interfaces in rda_if.sv
//
// usage
//   detent : input channel, one beat per encoder detent (direction, event_time)
//   result : output channel, one step beat for every detent beat
//   cfg    : write channel for reverse_guard_ticks, always ready, write only while idle
// timing
//   one detent is in flight at a time; detent.ready is high only in the idle state
//   rejected, counted or lone detents: the step is set in the eval state and shown
//   in the out state
//   accelerated detents run a restoring divider, one quotient bit per cycle for
//   all QUO_W (29) quotient bits, then the fin state sets the step for the out state
//   the divider's single subtract/compare is shared by every quotient bit
// reset
//   arst_n clears the guard to 10, the last direction to none, count and last time to 0
// stall
//   the step waits in its output register until result.ready; no new detent is
//   taken until then

module rotary_dial_acceleration import rda_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	rda_in_if.sink   detent,
	rda_out_if.source result,
	rda_cfg_if.sink  cfg
);

	state_t state_q, state_nxt;

	// configuration and tracking state
	logic [GUARD_W-1:0]    guard_q;
	dir_t                  last_dir_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TIME_WIDTH-1:0] last_time_q;

	// captured detent
	logic                  ccw_q;
	logic [TIME_WIDTH-1:0] now_q;

	// divider registers
	logic [TIME_WIDTH-1:0] rem_q;
	logic [TIME_WIDTH-1:0] dvs_q;
	logic [QUO_W-1:0]      dvd_q;
	logic [QUO_W-1:0]      quo_q;
	logic [DIV_CNT_W-1:0]  iter_q;

	logic signed [STEP_W-1:0] step_q;

	// decision logic, evaluated on the captured detent
	dir_t                  dir_code;
	logic [TIME_WIDTH-1:0] guard_sum;
	logic [TIME_WIDTH-1:0] gap_sum;
	logic                  rev_ok;
	logic                  same_time;
	logic                  lone;
	logic [CNT_W-1:0]      cnt_inc;
	logic [TIME_WIDTH-1:0] elapsed;
	logic [STEP_W-1:0]     unit;

	// shared divider step
	logic [TIME_WIDTH:0]   trial;
	logic [TIME_WIDTH:0]   diff;
	logic                  ge;
	logic                  div_last;

	// final step from quotient
	logic [STEP_W-1:0]     mag;

	localparam logic [DIV_CNT_W-1:0] ITER_LAST = DIV_CNT_W'(QUO_W - 1);

	assign dir_code  = ccw_q ? DIR_CCW : DIR_CW;
	// all tick sums wrap at the time width
	assign guard_sum = last_time_q + TIME_WIDTH'(guard_q);
	assign gap_sum   = last_time_q + TIME_WIDTH'(2);
	assign rev_ok    = guard_sum < now_q;
	assign same_time = last_time_q == now_q;
	assign lone      = (gap_sum <= now_q) && (cnt_q == CNT_W'(1));
	assign cnt_inc   = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);
	assign elapsed   = now_q - last_time_q;
	assign unit      = ccw_q ? {STEP_W{1'b1}} : STEP_W'(1);

	// restoring division: bring in the next dividend bit, subtract if it fits
	assign trial    = {rem_q, dvd_q[QUO_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign ge       = trial >= {1'b0, dvs_q};
	assign div_last = iter_q == ITER_LAST;

	assign mag = STEP_W'(quo_q);

	assign cfg.ready = 1'b1;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_nxt    = state_q;
		detent.ready = 1'b0;
		result.valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				detent.ready = 1'b1;
				if (detent.valid) begin
					state_nxt = ST_EVAL;
				end
			end
			ST_EVAL: begin
				// only a detent in the same direction at a different tick, not lone, divides
				if ((last_dir_q == dir_code) && !same_time && !lone) begin
					state_nxt = ST_DIV;
				end else begin
					state_nxt = ST_OUT;
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				result.valid = 1'b1;
				if (result.ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// guard register, written from the config channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q <= GUARD_RESET;
		end else if (cfg.valid && cfg.ready) begin
			guard_q <= cfg.data;
		end
	end

	// tracking state, updated once per detent in the eval cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_dir_q  <= DIR_NONE;
			cnt_q       <= '0;
			last_time_q <= '0;
		end else if (state_q == ST_EVAL) begin
			if (last_dir_q != dir_code) begin
				// reversal or first detent, accepted only past the guard
				if (rev_ok) begin
					last_dir_q  <= dir_code;
					cnt_q       <= CNT_W'(1);
					last_time_q <= now_q;
				end
			end else if (same_time) begin
				cnt_q <= cnt_inc;
			end else if (!lone) begin
				cnt_q       <= CNT_W'(1);
				last_time_q <= now_q;
			end
		end
	end

	// capture, divider and output payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (detent.valid) begin
					ccw_q <= detent.direction;
					now_q <= detent.event_time;
				end
			end
			ST_EVAL: begin
				if (last_dir_q != dir_code) begin
					step_q <= rev_ok ? unit : '0;
				end else if (same_time) begin
					step_q <= '0;
				end else if (lone) begin
					step_q <= unit;
				end else begin
					// divide 2^(4*incremented count) by the elapsed ticks, never zero here
					rem_q  <= '0;
					dvs_q  <= elapsed;
					dvd_q  <= QUO_W'(1) << {cnt_inc, 2'b00};
					quo_q  <= '0;
					iter_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q  <= ge ? diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
				quo_q  <= {quo_q[QUO_W-2:0], ge};
				dvd_q  <= {dvd_q[QUO_W-2:0], 1'b0};
				iter_q <= iter_q + DIV_CNT_W'(1);
			end
			ST_FIN: begin
				// a zero quotient still moves one unit
				if (quo_q == '0) begin
					step_q <= unit;
				end else if (ccw_q) begin
					step_q <= ~mag + STEP_W'(1);
				end else begin
					step_q <= mag;
				end
			end
			ST_OUT: begin
				step_q <= step_q;
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

	assign result.step = step_q;

endmodule

[hw/rtl/rda_checker.sv]
// rda_checker: port-level assertions for rotary_dial_acceleration, bound to the top level
// depends on rda_pkg for the step width

module rda_checker import rda_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              detent_valid,
	input logic              detent_ready,
	input logic              result_valid,
	input logic              result_ready,
	input logic [STEP_W-1:0] result_step
);

	// one detent in flight: no new beat while a step is pending
	a_busy_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !detent_ready)
		else $error("detent taken while a step is pending");

	// a detent beat is followed by a busy cycle
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(detent_valid && detent_ready) |=> !detent_ready)
		else $error("detent ready right after a detent beat");

	// stalled step holds
	a_step_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result_step)))
		else $error("stalled step changed or dropped");

	// magnitude never exceeds 2^28
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result_step[STEP_W-1] == result_step[STEP_W-2]) ||
			(result_step == STEP_W'(1 << (STEP_W - 2)))))
		else $error("step out of range");

endmodule

bind rotary_dial_acceleration rda_checker u_rda_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.detent_valid (detent.valid),
	.detent_ready (detent.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_step  (result.step)
);
